// ===== hw/rtl/wmq_pkg.sv =====
// Package for the window match queue: word types, request and status codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package wmq_pkg;

  // Request codes.
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_MATCHED   = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_PRESENT   = 3'd5;
  localparam logic [2:0] ST_EXPIRED   = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_RATING_WINDOW = 1'b0;
  localparam logic CFG_WAIT_TIMEOUT  = 1'b1;

  localparam logic [11:0] RATING_WINDOW_RESET = 12'd100;
  localparam logic [31:0] WAIT_TIMEOUT_RESET  = 32'd60000;

  // Most entries that one tick may expire, and the width of that count.
  localparam int MAX_RESULTS = 32;
  localparam int XCNT_W      = 6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] player_id;
    logic [11:0] player_rating;
    logic [31:0] time_now;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] partner_id;
    logic [11:0] partner_rating;
    logic [31:0] partner_time;
    logic        entry_valid;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [11:0] rating;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic read;
    logic eval;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_emit;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/wmq_ctrl.sv =====
// Controller of the window match queue: sequences the scan over the queue.
// Depends on wmq_pkg.
module wmq_ctrl
  import wmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     idle,
  output ctl_cmd_t cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.read   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat.need_emit || stat.out_free) begin
          cmd.eval   = 1'b1;
          state_next = S_READ;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

endmodule

// ===== hw/rtl/wmq_datapath.sv =====
// Datapath of the window match queue: entry memory, scan pointers, the held
// result, the output register and the configuration registers.
// Depends on wmq_pkg.
module wmq_datapath
  import wmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  in_word_t    in_word,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata;

  logic [11:0]       rating_window;
  logic [31:0]       wait_timeout;
  in_word_t          req;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     rd;
  logic [CW-1:0]     wr;
  logic              found;
  logic [XCNT_W-1:0] xcount;
  logic              pend_valid;
  entry_t            pend;

  logic [11:0] rating_diff;
  logic [31:0] age;
  logic        id_hit;
  logic        drop;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t      mem_wdata;
  entry_t      new_entry;
  out_word_t   final_word;

  // Per-entry decision on the word read from memory.
  always_comb begin
    rating_diff = (rdata.rating > req.player_rating) ? rdata.rating - req.player_rating
                                                     : req.player_rating - rdata.rating;
    age    = req.time_now - rdata.stamp;
    id_hit = (rdata.id == req.player_id);
    case (req.req_type)
      REQ_ENQUEUE: drop = !found && (rating_diff <= rating_window);
      REQ_REMOVE:  drop = !found && id_hit;
      REQ_QUERY:   drop = 1'b0;
      REQ_TICK:    drop = (xcount < XCNT_W'(MAX_RESULTS)) && (age >= wait_timeout);
      default:     drop = 1'b0;
    endcase
  end

  assign new_entry = '{id: req.player_id, rating: req.player_rating, stamp: req.time_now};

  assign stat.scan_done = (rd == fill);
  assign stat.need_emit = (req.req_type == REQ_TICK) && drop && pend_valid;
  assign stat.out_free  = !out_valid || !out_stall;

  // Memory write: kept entries compact toward the head; enqueue appends at the end.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr[AW-1:0];
    mem_wdata = rdata;
    if (cmd.eval && !drop) begin
      mem_we = 1'b1;
    end else if (cmd.finish && req.req_type == REQ_ENQUEUE && !found &&
                 wr < CW'(QUEUE_DEPTH)) begin
      mem_we    = 1'b1;
      mem_wdata = new_entry;
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rdata <= mem[rd[AW-1:0]];
    end
  end

  // Request register and held partner entry.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_word;
    end
    if (cmd.eval && drop) begin
      pend <= rdata;
    end
  end

  // Control state of the scan and the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      rating_window <= RATING_WINDOW_RESET;
      wait_timeout  <= WAIT_TIMEOUT_RESET;
      fill          <= '0;
      rd            <= '0;
      wr            <= '0;
      found         <= 1'b0;
      xcount        <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_RATING_WINDOW) begin
          rating_window <= cfg_wdata[11:0];
        end else begin
          wait_timeout <= cfg_wdata;
        end
      end
      if (cmd.load) begin
        rd         <= '0;
        wr         <= '0;
        found      <= 1'b0;
        xcount     <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.eval) begin
        rd <= rd + CW'(1);
        if (drop) begin
          found      <= 1'b1;
          pend_valid <= 1'b1;
          if (req.req_type == REQ_TICK) begin
            xcount <= xcount + XCNT_W'(1);
          end
        end else begin
          wr <= wr + CW'(1);
          if (req.req_type == REQ_QUERY && id_hit) begin
            found <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        if (req.req_type == REQ_ENQUEUE && !found && wr < CW'(QUEUE_DEPTH)) begin
          fill <= wr + CW'(1);
        end else begin
          fill <= wr;
        end
      end
    end
  end

  // Final result word of a request, built from the scan outcome.
  always_comb begin
    final_word = '{status: ST_EXPIRED, partner_id: '0, partner_rating: '0,
                   partner_time: '0, entry_valid: 1'b0, last_result: 1'b1};
    case (req.req_type)
      REQ_ENQUEUE: begin
        if (found) begin
          final_word.status         = ST_MATCHED;
          final_word.partner_id     = pend.id;
          final_word.partner_rating = pend.rating;
          final_word.partner_time   = pend.stamp;
          final_word.entry_valid    = 1'b1;
        end else if (wr < CW'(QUEUE_DEPTH)) begin
          final_word.status = ST_QUEUED;
        end else begin
          final_word.status = ST_FULL;
        end
      end
      REQ_REMOVE: final_word.status = found ? ST_REMOVED : ST_NOT_FOUND;
      REQ_QUERY:  final_word.status = found ? ST_PRESENT : ST_NOT_FOUND;
      REQ_TICK: begin
        if (pend_valid) begin
          final_word.partner_id     = pend.id;
          final_word.partner_rating = pend.rating;
          final_word.partner_time   = pend.stamp;
          final_word.entry_valid    = 1'b1;
        end
      end
      default: final_word.status = ST_EXPIRED;
    endcase
  end

  // Output register: intermediate expiries during the scan, final word at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.eval && stat.need_emit) begin
      out_valid <= 1'b1;
      out_word  <= '{status: ST_EXPIRED, partner_id: pend.id, partner_rating: pend.rating,
                     partner_time: pend.stamp, entry_valid: 1'b1, last_result: 1'b0};
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      out_word  <= final_word;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The queue never holds more entries than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  // Compaction never writes ahead of the read pointer.
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    wr <= rd)
    else $error("write pointer ahead of read pointer");

  // A tick expires no more entries than one request may report.
  a_xcount_bound: assert property (@(posedge clk) disable iff (rst)
    xcount <= XCNT_W'(MAX_RESULTS))
    else $error("expiry count beyond limit");

endmodule

// ===== hw/rtl/window_match_queue_unit.sv =====
// Window match queue: ordered waiting queue with rating-window pairing.
// Each request scans the queued entries in turn, a registered read and an
// evaluation for each, and the final result word is written after the scan; a
// stalled output can hold both the scan and the final word. A new request is
// taken only when the block is back in idle, after that final word. Synchronous
// reset empties the queue and loads the register reset values.
module window_match_queue_unit
  import wmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     idle;

  // Sequencer.
  wmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .idle     (idle),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Storage and result logic.
  wmq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign in_stall = !idle;

endmodule

// ===== dv/tb_window_match_queue_unit.sv =====
// Self-checking testbench for window_match_queue_unit: a queue predictor in a
// scoreboard class, random and directed request words, random idling.
// Depends on wmq_pkg and the window_match_queue_unit RTL.
`timescale 1ns / 100ps

module tb_window_match_queue_unit;
  import wmq_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 1000000;

  // Predictor of the queue, and the results it expects in order.
  class match_scoreboard;
    entry_t    slots[$];
    logic [11:0] window;
    logic [31:0] timeout;
    out_word_t expected_words[$];
    int        errors;
    int        checked;

    function new();
      window = RATING_WINDOW_RESET;
      timeout = WAIT_TIMEOUT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void push_word(logic [2:0] st, entry_t e, logic has_entry, logic last);
      out_word_t w;
      w.status = st;
      w.partner_id = has_entry ? e.id : 32'd0;
      w.partner_rating = has_entry ? e.rating : 12'd0;
      w.partner_time = has_entry ? e.stamp : 32'd0;
      w.entry_valid = has_entry;
      w.last_result = last;
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void note_request(in_word_t req);
      entry_t e;
      entry_t blank;
      int pos;
      int count;
      int i;
      logic [11:0] diff;
      logic [31:0] age;
      blank = '0;
      pos = -1;
      case (req.req_type)
        REQ_ENQUEUE: begin
          for (i = 0; i < slots.size(); i++) begin
            diff = slots[i].rating > req.player_rating ?
                   slots[i].rating - req.player_rating : req.player_rating - slots[i].rating;
            if (pos < 0 && diff <= window) pos = i;
          end
          if (pos >= 0) begin
            push_word(ST_MATCHED, slots[pos], 1'b1, 1'b1);
            slots.delete(pos);
          end else if (slots.size() < DEPTH) begin
            e.id = req.player_id;
            e.rating = req.player_rating;
            e.stamp = req.time_now;
            slots.insert(slots.size(), e);
            push_word(ST_QUEUED, blank, 1'b0, 1'b1);
          end else begin
            push_word(ST_FULL, blank, 1'b0, 1'b1);
          end
        end
        REQ_REMOVE, REQ_QUERY: begin
          for (i = 0; i < slots.size(); i++)
            if (pos < 0 && slots[i].id == req.player_id) pos = i;
          if (req.req_type == REQ_QUERY)
            push_word(pos >= 0 ? ST_PRESENT : ST_NOT_FOUND, blank, 1'b0, 1'b1);
          else if (pos >= 0) begin
            slots.delete(pos);
            push_word(ST_REMOVED, blank, 1'b0, 1'b1);
          end else
            push_word(ST_NOT_FOUND, blank, 1'b0, 1'b1);
        end
        default: begin
          count = 0;
          i = 0;
          while (i < slots.size() && count < MAX_RESULTS) begin
            age = req.time_now - slots[i].stamp;
            if (age >= timeout) begin
              push_word(ST_EXPIRED, slots[i], 1'b1, 1'b0);
              slots.delete(i);
              count++;
            end else
              i++;
          end
          if (count == 0)
            push_word(ST_EXPIRED, blank, 1'b0, 1'b1);
          else
            expected_words[expected_words.size() - 1].last_result = 1'b1;
        end
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: %p", got);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status); errors++;
      end
      if (got.partner_id !== exp.partner_id) begin
        $error("partner_id: expected %h, actual %h", exp.partner_id, got.partner_id);
        errors++;
      end
      if (got.partner_rating !== exp.partner_rating) begin
        $error("partner_rating: expected %0d, actual %0d", exp.partner_rating,
               got.partner_rating);
        errors++;
      end
      if (got.partner_time !== exp.partner_time) begin
        $error("partner_time: expected %h, actual %h", exp.partner_time, got.partner_time);
        errors++;
      end
      if (got.entry_valid !== exp.entry_valid) begin
        $error("entry_valid: expected %0d, actual %0d", exp.entry_valid, got.entry_valid);
        errors++;
      end
      if (got.last_result !== exp.last_result) begin
        $error("last_result: expected %0d, actual %0d", exp.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;

  match_scoreboard board;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  cycle_count;
  int  requests_sent;
  int  ids_pool[$];
  logic [31:0] clock_now;

  window_match_queue_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(out_word);
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_RATING_WINDOW) board.window = value[11:0];
    else board.timeout = value;
    @(posedge clk);
  endtask

  // Offers one request word and holds it until it is accepted.
  task automatic send_request(in_word_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
    requests_sent++;
  endtask

  // Stops offering, waits for every expected word, then for the block to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
  endtask

  function automatic in_word_t make_req(logic [1:0] kind, logic [31:0] id,
                                        logic [11:0] rating, logic [31:0] stamp);
    in_word_t r;
    r.req_type = kind;
    r.player_id = id;
    r.player_rating = rating;
    r.time_now = stamp;
    return r;
  endfunction

  // Random request, mostly well formed: known ids, a moving clock.
  function automatic in_word_t random_req();
    int pick;
    logic [31:0] id;
    pick = $urandom_range(99);
    clock_now = clock_now + $urandom_range(400);
    if (ids_pool.size() > 0 && $urandom_range(2) != 0)
      id = ids_pool[$urandom_range(ids_pool.size() - 1)];
    else begin
      id = $urandom();
      ids_pool.insert(ids_pool.size(), id);
      if (ids_pool.size() > 40) void'(ids_pool.pop_front());
    end
    if (pick < 55)
      return make_req(REQ_ENQUEUE, id, 12'($urandom_range(4095)),
                      $urandom_range(15) == 0 ? $urandom() : clock_now);
    else if (pick < 70) return make_req(REQ_REMOVE, id, 12'($urandom()), $urandom());
    else if (pick < 85) return make_req(REQ_QUERY, id, 12'($urandom()), $urandom());
    else return make_req(REQ_TICK, $urandom(), 12'($urandom()),
                         $urandom_range(7) == 0 ? $urandom() : clock_now);
  endfunction

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(random_req());
    drain();
  endtask

  initial begin
    int i;
    board = new();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_RATING_WINDOW;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_word = '0;
    hold_off = 1'b0;
    requests_sent = 0;
    clock_now = 32'd1000;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: misses, match, duplicates, ticks.
    send_request(make_req(REQ_QUERY, 32'hFFFF_FFFF, 12'd0, 32'd0));
    send_request(make_req(REQ_REMOVE, 32'd0, 12'd0, 32'd0));
    send_request(make_req(REQ_TICK, 32'd0, 12'd0, 32'd0));
    send_request(make_req(REQ_ENQUEUE, 32'd7, 12'd0, 32'd0));
    send_request(make_req(REQ_ENQUEUE, 32'd7, 12'd4095, 32'hFFFF_FFFF));
    send_request(make_req(REQ_QUERY, 32'd7, 12'd0, 32'd0));
    send_request(make_req(REQ_ENQUEUE, 32'd9, 12'd100, 32'd5));
    send_request(make_req(REQ_REMOVE, 32'd7, 12'd0, 32'd0));
    send_request(make_req(REQ_TICK, 32'd0, 12'd0, 32'd59998));
    send_request(make_req(REQ_TICK, 32'd0, 12'd0, 32'd59999));
    drain();

    // Fill the queue past full, then expire everything with a zero timeout.
    write_reg(CFG_RATING_WINDOW, 32'd0);
    write_reg(CFG_WAIT_TIMEOUT, 32'hFFFF_FFFF);
    for (i = 0; i < DEPTH + 2; i++)
      send_request(make_req(REQ_ENQUEUE, i, 12'(i * 100), 32'(i)));
    send_request(make_req(REQ_TICK, 32'd0, 12'd0, 32'd30));
    drain();
    write_reg(CFG_WAIT_TIMEOUT, 32'd0);
    send_request(make_req(REQ_TICK, 32'd0, 12'd0, 32'd0));
    drain();

    // Random phases across several register settings and idling mixes.
    write_reg(CFG_RATING_WINDOW, 32'd100);
    write_reg(CFG_WAIT_TIMEOUT, 32'd3000);
    random_phase(60, 0, 0);
    write_reg(CFG_RATING_WINDOW, 32'd4095);
    write_reg(CFG_WAIT_TIMEOUT, 32'd60000);
    random_phase(40, 83, 0);
    write_reg(CFG_RATING_WINDOW, 32'd20);
    write_reg(CFG_WAIT_TIMEOUT, 32'd1500);
    random_phase(80, 0, 83);
    write_reg(CFG_RATING_WINDOW, 32'd300);
    write_reg(CFG_WAIT_TIMEOUT, 32'hFFFF_FFFF);
    random_phase(70, 31, 31);

    // Long receiver hold-off while requests keep coming.
    write_reg(CFG_RATING_WINDOW, 32'd50);
    write_reg(CFG_WAIT_TIMEOUT, 32'd2000);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (40) send_request(random_req());
      end
    join
    drain();
    random_phase(20, 0, 0);

    $display("Sent %0d requests and checked %0d result words across several register settings.",
             requests_sent, board.checked);
    if (board.errors == 0 && board.expected_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== window_match_queue_unit.f =====
hw/rtl/wmq_pkg.sv
hw/rtl/wmq_ctrl.sv
hw/rtl/wmq_datapath.sv
hw/rtl/window_match_queue_unit.sv
dv/tb_window_match_queue_unit.sv
